[sv/utf8_validity_prober_core_macros.svh]
// assertion macros for the utf8 validity prober
`ifndef UTF8_VALIDITY_PROBER_CORE_MACROS_SVH
`define UTF8_VALIDITY_PROBER_CORE_MACROS_SVH

`ifndef SYNTH
`define UVP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 prober next-cycle check failed");
`define UVP_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("utf8 prober invariant failed");
`else
`define UVP_ASSERT_NEXT(label, ante, cons)
`define UVP_ASSERT_ALWAYS(label, expr)
`endif

`endif

[sv/utf8vp_pkg.sv]
// types, constants and lookup tables of the utf8 validity prober
package utf8vp_pkg;

	localparam logic [3:0] ST_START = 4'd0;
	localparam logic [3:0] ST_ERROR = 4'd1;
	localparam logic [3:0] ST_FOUND = 4'd2;
	localparam logic [2:0] COUNT_MAX = 3'd6;
	localparam logic [16:0] CONF_FOUND = 17'd65536;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  code_state;
		logic        found;
		logic [2:0]  char_length;
		logic [2:0]  multibyte_count;
		logic [16:0] confidence_q16;
	} out_item_t;

	function automatic logic [3:0] classify_byte(input logic [7:0] b);
		logic [3:0] c;
		c = 4'd0;
		case (b) inside
			8'h0E, 8'h0F, 8'h1B:  c = 4'd0;
			[8'h00:8'h7F]:        c = 4'd1;
			[8'h80:8'h83]:        c = 4'd2;
			[8'h84:8'h87]:        c = 4'd3;
			[8'h88:8'h9F]:        c = 4'd4;
			[8'hA0:8'hBF]:        c = 4'd5;
			8'hC0, 8'hC1:         c = 4'd0;
			[8'hC2:8'hDF]:        c = 4'd6;
			8'hE0:                c = 4'd7;
			8'hED:                c = 4'd9;
			[8'hE1:8'hEF]:        c = 4'd8;
			8'hF0:                c = 4'd10;
			[8'hF1:8'hF7]:        c = 4'd11;
			8'hF8:                c = 4'd12;
			[8'hF9:8'hFB]:        c = 4'd13;
			8'hFC:                c = 4'd14;
			8'hFD:                c = 4'd15;
			default:              c = 4'd0;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] class_length(input logic [3:0] c);
		logic [2:0] l;
		l = 3'd0;
		unique case (c)
			4'd1:                 l = 3'd1;
			4'd6:                 l = 3'd2;
			4'd7, 4'd8, 4'd9:     l = 3'd3;
			4'd10, 4'd11:         l = 3'd4;
			4'd12, 4'd13:         l = 3'd5;
			4'd14, 4'd15:         l = 3'd6;
			default:              l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [3:0] start_next(input logic [3:0] c);
		logic [3:0] n;
		n = ST_ERROR;
		unique case (c)
			4'd1:    n = ST_START;
			4'd6:    n = 4'd12;
			4'd7:    n = 4'd10;
			4'd8:    n = 4'd9;
			4'd9:    n = 4'd11;
			4'd10:   n = 4'd8;
			4'd11:   n = 4'd7;
			4'd12:   n = 4'd6;
			4'd13:   n = 4'd5;
			4'd14:   n = 4'd4;
			4'd15:   n = 4'd3;
			default: n = ST_ERROR;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] advance_state(input logic [3:0] s, input logic [3:0] c);
		logic [3:0] n;
		logic       cont;
		logic       low;
		cont = (c >= 4'd2) && (c <= 4'd5);
		low  = (c >= 4'd2) && (c <= 4'd4);
		n = ST_ERROR;
		unique case (s)
			ST_START: n = start_next(c);
			ST_ERROR: n = ST_ERROR;
			ST_FOUND: n = ST_FOUND;
			4'd3:     n = cont ? 4'd5 : ST_ERROR;
			4'd4:     n = (c == 4'd3 || c == 4'd4 || c == 4'd5) ? 4'd5 : ST_ERROR;
			4'd5:     n = cont ? 4'd7 : ST_ERROR;
			4'd6:     n = (c == 4'd4 || c == 4'd5) ? 4'd7 : ST_ERROR;
			4'd7:     n = cont ? 4'd9 : ST_ERROR;
			4'd8:     n = (c == 4'd5) ? 4'd9 : ST_ERROR;
			4'd9:     n = cont ? 4'd12 : ST_ERROR;
			4'd10:    n = (c == 4'd5) ? 4'd12 : ST_ERROR;
			4'd11:    n = low ? 4'd12 : ST_ERROR;
			4'd12:    n = cont ? ST_START : ST_ERROR;
			default:  n = ST_ERROR;
		endcase
		return n;
	endfunction

	function automatic logic [16:0] confidence(input logic [2:0] cnt);
		logic [16:0] q;
		q = 17'd64881;
		unique case (cnt)
			3'd0:    q = 17'd655;
			3'd1:    q = 17'd33096;
			3'd2:    q = 17'd49316;
			3'd3:    q = 17'd57426;
			3'd4:    q = 17'd61481;
			3'd5:    q = 17'd63508;
			default: q = 17'd64881;
		endcase
		return q;
	endfunction

endpackage

[sv/utf8vp_classifier.sv]
// byte classifier: maps a raw byte to its 4-bit coding class
module utf8vp_classifier import utf8vp_pkg::*; (
	input  logic [7:0] data_byte,
	output logic [3:0] byte_cls
);

	assign byte_cls = classify_byte(data_byte);

endmodule

[sv/utf8vp_machine.sv]
// coding state machine, length latch and wide character counter
`include "utf8_validity_prober_core_macros.svh"

module utf8vp_machine import utf8vp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       last_byte,
	input  logic [3:0] byte_cls,
	output out_item_t  result
);

	logic [3:0] state_q;
	logic [2:0] length_q;
	logic [2:0] count_q;

	logic [3:0] state_d;
	logic [2:0] length_d;
	logic [2:0] count_d;

	always_comb begin
		length_d = (state_q == ST_START) ? class_length(byte_cls) : length_q;
		state_d  = advance_state(state_q, byte_cls);
		count_d  = count_q;
		if (state_d == ST_START && length_d > 3'd2 && count_q < COUNT_MAX) begin
			count_d = count_q + 3'd1;
		end
	end

	always_comb begin
		result.code_state      = state_d;
		result.found           = (state_d == ST_FOUND);
		result.char_length     = length_d;
		result.multibyte_count = count_d;
		result.confidence_q16  = (state_d == ST_FOUND) ? CONF_FOUND : confidence(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			length_q <= 3'd0;
			count_q  <= 3'd0;
		end else if (accept) begin
			if (last_byte) begin
				state_q  <= ST_START;
				length_q <= 3'd0;
				count_q  <= 3'd0;
			end else begin
				state_q  <= state_d;
				length_q <= length_d;
				count_q  <= count_d;
			end
		end
	end

	`UVP_ASSERT_NEXT(a_last_resets, accept && last_byte, state_q == ST_START && count_q == 3'd0)
	`UVP_ASSERT_NEXT(a_error_sticky, accept && !last_byte && state_q == ST_ERROR, state_q == ST_ERROR)
	`UVP_ASSERT_NEXT(a_count_monotonic, accept && !last_byte, count_q >= $past(count_q))
	`UVP_ASSERT_ALWAYS(a_count_bound, count_q <= COUNT_MAX && state_q <= 4'd12)

endmodule

[sv/utf8_validity_prober_core.sv]
// utf8 validity prober top level: input handshake, state machine and result register
//
// byte channel: byte_valid / byte_stall / byte_data carry one text byte and its
// last-byte mark per transfer. result channel: result_valid / result_stall /
// result_data carry the coding state, found flag, latched character length,
// wide character count and Q1.16 confidence after each byte.
// every accepted byte gives exactly one result, in order.
// the result of a byte is registered and presented the cycle after its transfer.
// throughput: one byte per cycle while byte_stall is low; the class lookup, state
// table lookup and counter update sit between the state and result registers.
// byte_stall rises only while a result is held and result_stall is high, so
// a new byte is taken in the same cycle the held result is transferred.
// after a byte marked last, state, length and count return to start.
// reset clears the state machine, the counter and the result valid flag.
module utf8_validity_prober_core import utf8vp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_data,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	logic      accept;
	logic [3:0] byte_cls;
	out_item_t next_result;
	logic      result_valid_q;
	out_item_t result_q;

	assign byte_stall = result_valid_q && result_stall;
	assign accept     = byte_valid && !byte_stall;

	utf8vp_classifier u_classifier (
		.data_byte (byte_data.data_byte),
		.byte_cls  (byte_cls)
	);

	utf8vp_machine u_machine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.last_byte (byte_data.last_byte),
		.byte_cls  (byte_cls),
		.result    (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule
